FILE: rtl/victim_buffer_ring_top_macros.svh
// assertion macros for the victim buffer ring
`ifndef VICTIM_BUFFER_RING_TOP_MACROS_SVH
`define VICTIM_BUFFER_RING_TOP_MACROS_SVH
`ifndef SYNTHESIS
// antecedent in this cycle, consequent in the next
`define VBR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("victim buffer ring check failed");
// antecedent and consequent in the same cycle
`define VBR_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("victim buffer ring check failed");
`else
`define VBR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`define VBR_ASSERT_SAME(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/vbr_pkg.sv
package vbr_pkg;

    localparam int VBR_ENTRIES = 8;
    localparam int VBR_IDX_W   = 3;
    localparam int VBR_CNT_W   = VBR_IDX_W + 1;
    localparam int VBR_MODE_W  = 3;
    localparam int VBR_TYPE_W  = 2;
    localparam int VBR_ADDR_W  = 44;
    localparam int VBR_DATA_W  = 64;

    typedef logic [VBR_IDX_W-1:0]   t_idx;
    typedef logic [VBR_CNT_W-1:0]   t_cnt;
    typedef logic [VBR_ENTRIES-1:0] t_mask;

    typedef enum logic [VBR_MODE_W-1:0] {
        MODE_ADD       = 3'd0,
        MODE_PROCESS   = 3'd1,
        MODE_CLR_PROBE = 3'd2,
        MODE_FREE      = 3'd3,
        MODE_MATCH     = 3'd4
    } t_mode;

    typedef struct packed {
        logic [VBR_MODE_W-1:0] mode;
        t_idx                  entry_index;
        logic [VBR_TYPE_W-1:0] block_type;
        logic [VBR_ADDR_W-1:0] addr;
        logic [VBR_DATA_W-1:0] data_word;
        logic                  probe_flag;
    } t_in_word;

    typedef struct packed {
        t_idx                  slot_used;
        logic [VBR_TYPE_W-1:0] out_type;
        logic [VBR_ADDR_W-1:0] out_addr;
        logic [VBR_DATA_W-1:0] out_data;
        logic                  addr_hit;
        logic                  pending_found;
        t_idx                  pending_slot;
    } t_out_word;

    typedef struct packed {
        logic found;
        t_idx idx;
    } t_pick;

    function automatic t_idx ring_next(t_idx p);
        return (p == t_idx'(VBR_ENTRIES - 1)) ? '0 : t_idx'(p + 1'b1);
    endfunction

    // slots from head to tail inclusive, in ring order
    function automatic t_mask win_mask(t_idx h, t_idx t);
        t_mask m;
        t_idx  ii;
        for (int i = 0; i < VBR_ENTRIES; i++) begin
            ii = t_idx'(i);
            m[i] = (t >= h) ? ((ii >= h) && (ii <= t)) : ((ii >= h) || (ii <= t));
        end
        return m;
    endfunction

    // first set bit of mask, scanning from start with wrap
    function automatic t_pick first_from(t_mask mask, t_idx start);
        t_pick r;
        t_cnt  s;
        r = '0;
        for (int i = VBR_ENTRIES - 1; i >= 0; i--) begin
            s = t_cnt'({1'b0, start}) + t_cnt'(i);
            if (s >= t_cnt'(VBR_ENTRIES)) begin
                s = s - t_cnt'(VBR_ENTRIES);
            end
            if (mask[s[VBR_IDX_W-1:0]]) begin
                r.found = 1'b1;
                r.idx   = s[VBR_IDX_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/vbr_chan_if.sv
interface vbr_chan_if #(parameter type t_word = logic);
    logic  valid;
    logic  ready;
    t_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

FILE: rtl/vbr_in_stage.sv
module vbr_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vbr_chan_if.sink          i_in,
    input  logic              i_adv,
    output logic              o_vld,
    output vbr_pkg::t_in_word o_word
);
    import vbr_pkg::*;

    logic     r_vld;
    t_in_word r_word;
    logic     w_take;

    assign i_in.ready = !r_vld || i_adv;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word <= i_in.word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;
endmodule

FILE: rtl/vbr_core.sv
module vbr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  vbr_pkg::t_in_word  i_word,
    output vbr_pkg::t_out_word o_res
);
    import vbr_pkg::*;

    t_mask r_valid, r_done, r_probe;
    t_idx  r_head, r_tail;
    logic [VBR_TYPE_W-1:0] r_type [VBR_ENTRIES];
    logic [VBR_ADDR_W-1:0] r_addr [VBR_ENTRIES];
    logic [VBR_DATA_W-1:0] r_data [VBR_ENTRIES];

    t_mask n_valid, n_done, n_probe;
    t_idx  n_head, n_tail;

    t_idx      w_e;
    t_idx      w_add_slot;
    t_mask     w_e_hot;
    t_mask     w_win;
    t_mask     w_addr_eq;
    t_pick     w_free_pick;
    t_pick     w_pend;
    logic      w_wr_add;
    t_out_word w_res;

    assign w_e        = i_word.entry_index;
    assign w_e_hot    = t_mask'(1) << w_e;
    assign w_win      = win_mask(r_head, r_tail);
    assign w_add_slot = r_valid[r_tail] ? ring_next(r_tail) : r_tail;
    // leading invalid slots after the free
    assign w_free_pick = first_from(r_valid & ~w_e_hot & w_win, r_head);

    always_comb begin
        for (int i = 0; i < VBR_ENTRIES; i++) begin
            w_addr_eq[i] = (r_addr[i] == i_word.addr);
        end
    end

    always_comb begin
        n_valid  = r_valid;
        n_done   = r_done;
        n_probe  = r_probe;
        n_head   = r_head;
        n_tail   = r_tail;
        w_wr_add = 1'b0;
        w_res    = '0;
        w_res.slot_used = w_e;
        case (i_word.mode)
            MODE_ADD: begin
                n_tail              = w_add_slot;
                n_valid[w_add_slot] = 1'b1;
                n_done[w_add_slot]  = 1'b0;
                n_probe[w_add_slot] = i_word.probe_flag;
                w_wr_add            = 1'b1;
                w_res.slot_used     = w_add_slot;
            end
            MODE_PROCESS: begin
                n_done[w_e]    = 1'b1;
                w_res.out_type = r_type[w_e];
                w_res.out_addr = r_addr[w_e];
                w_res.out_data = r_data[w_e];
            end
            MODE_CLR_PROBE: begin
                n_probe[w_e] = 1'b0;
            end
            MODE_FREE: begin
                n_valid[w_e] = 1'b0;
                n_head = w_free_pick.found ? w_free_pick.idx : ring_next(r_tail);
            end
            MODE_MATCH: begin
                w_res.addr_hit = |(r_valid & r_probe & w_win & w_addr_eq);
            end
            default: begin
            end
        endcase
    end

    assign w_pend = first_from(n_valid & ~n_done & win_mask(n_head, n_tail), n_head);

    always_comb begin
        o_res = w_res;
        o_res.pending_found = w_pend.found;
        o_res.pending_slot  = w_pend.found ? w_pend.idx : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= '0;
            r_probe <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_done  <= n_done;
            r_probe <= n_probe;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_wr_add) begin
            r_type[w_add_slot] <= i_word.block_type;
            r_addr[w_add_slot] <= i_word.addr;
            r_data[w_add_slot] <= i_word.data_word;
        end
    end
endmodule

FILE: rtl/victim_buffer_ring_top.sv
// victim buffer ring: each input word yields one registered result word
// throughput one word per cycle unless o_out stalls; the state update and scan set this
// an input register and a result register part the two channels
// reset is synchronous, active low: clears valid, processed and probe bits, both
// pointers and the stage valids; stored type, address and data are not cleared
module victim_buffer_ring_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vbr_chan_if.sink    i_in,
    vbr_chan_if.source  o_out
);
    import vbr_pkg::*;

    `include "victim_buffer_ring_top_macros.svh"

    // input register stage
    logic      w_in_vld;
    t_in_word  w_in_word;
    // core advances when an input word is held and the result register is free or being emptied
    logic      w_adv;
    t_out_word w_res;
    // result register
    logic      r_out_vld;
    t_out_word r_out;
    // operation being retired this cycle, for the checks
    logic      w_do_add;
    logic      w_not_match;
    logic      w_not_proc;
    logic      w_out_blank;

    assign w_adv = w_in_vld && (!r_out_vld || o_out.ready);

    vbr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (w_adv),
        .o_vld   (w_in_vld),
        .o_word  (w_in_word)
    );

    // ring state, operation decode and pending scan
    vbr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_word  (w_in_word),
        .o_res   (w_res)
    );

    // result register holds its word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.word  = r_out;

    assign w_do_add    = w_adv && (w_in_word.mode == MODE_ADD);
    assign w_not_match = w_adv && (w_in_word.mode != MODE_MATCH);
    assign w_not_proc  = w_adv && (w_in_word.mode != MODE_PROCESS);
    assign w_out_blank = (r_out.out_type == '0) && (r_out.out_addr == '0)
                         && (r_out.out_data == '0);

    // an added entry is always valid, unprocessed and inside the window
    `VBR_ASSERT_NEXT(a_add_pending, i_clk, i_rst_n, w_do_add, r_out.pending_found)
    // only a match query can report a hit
    `VBR_ASSERT_NEXT(a_hit_match_only, i_clk, i_rst_n, w_not_match, !r_out.addr_hit)
    // contents only come back for a process operation
    `VBR_ASSERT_NEXT(a_contents_process_only, i_clk, i_rst_n, w_not_proc, w_out_blank)
    // a stalled result word keeps the ring state frozen
    `VBR_ASSERT_SAME(a_stall_freezes, i_clk, i_rst_n, r_out_vld && !o_out.ready, !w_adv)
endmodule
